@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only once reset has been released
`define CLCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// checked on every edge, reset included
`define CLCD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/clcd_pkg.sv @@
package clcd_pkg;

  // request codes
  localparam logic [2:0] FUNC_CMD    = 3'd0;
  localparam logic [2:0] FUNC_DATA   = 3'd1;
  localparam logic [2:0] FUNC_CURSOR = 3'd2;
  localparam logic [2:0] FUNC_CLEAR  = 3'd3;
  localparam logic [2:0] FUNC_INIT   = 3'd4;

  // register indexes (paddr[2])
  localparam logic REG_PULSE_HOLD = 1'b0;
  localparam logic REG_POWER_WAIT = 1'b1;

  localparam logic [3:0] PULSE_HOLD_RESET = 4'd1;
  localparam logic [7:0] POWER_WAIT_RESET = 8'd50;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF = 8'h08;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [3:0] NIB_WAKE     = 4'h3;
  localparam logic [3:0] NIB_4BIT     = 4'h2;

  localparam logic [7:0] SETTLE_LONG  = 8'd5;
  localparam logic [7:0] SETTLE_CMD   = 8'd2;
  localparam logic [7:0] SETTLE_DATA  = 8'd1;

  // phase counters: five phases per byte, three per init nibble
  localparam logic [2:0] STEP_BYTE_LAST = 3'd4;
  localparam logic [2:0] STEP_NIB_LAST  = 3'd2;
  localparam logic [2:0] SEQ_NIB_LAST   = 3'd3;
  localparam logic [2:0] SEQ_BYTE_LAST  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PWR,
    ST_INIT_NIB,
    ST_INIT_BYTE,
    ST_BYTE,
    ST_EXTRA
  } state_t;

  typedef enum logic [2:0] {
    K_PWR,
    K_INIT_NIB,
    K_INIT_BYTE,
    K_BYTE,
    K_EXTRA
  } phase_kind_t;

  typedef struct packed {
    logic        load;
    logic        emit;
    phase_kind_t kind;
    logic [2:0]  step;
    logic [2:0]  seq;
    logic        last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  function automatic logic [7:0] init_byte(input logic [2:0] seq);
    logic [7:0] b;
    unique case (seq)
      3'd0:    b = CMD_FUNC_SET;
      3'd1:    b = CMD_DISP_OFF;
      3'd2:    b = CMD_CLEAR;
      3'd3:    b = CMD_ENTRY;
      default: b = CMD_DISP_ON;
    endcase
    return b;
  endfunction

endpackage

@@ design/char_lcd_4bit_write_sequencer_unit.sv @@
// Character LCD 4-bit write sequencer. Each accepted request (command, data,
// set cursor, clear, initialize) is turned into a run of pin phases, one beat
// per phase: register select, data nibble, enable level and a hold time in ms
// that the pin driver downstream applies. A byte goes out high nibble first,
// enable high then low per nibble, then a settle phase. The phase sequencer
// produces one phase per clock while the result side is not stalled, and takes
// the next request only after the last phase of the current one has been
// loaded. A clear request adds a long settle phase after its byte. Codes 5
// to 7 are dropped with no result. The user is to write pulse_hold_ms (0x0)
// and power_on_wait_ms (0x4) over the register port only while no request is
// in progress; the block itself does not enforce this.
module char_lcd_4bit_write_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [7:0]  byte_value,
  input  logic        row,
  input  logic [5:0]  col,
  // phase channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        reg_select,
  output logic [3:0]  nibble,
  output logic        enable,
  output logic [7:0]  hold_ms,
  output logic        last,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  clcd_pkg::ctrl_cmd_t  cmd;
  clcd_pkg::dp_status_t status;
  logic                 busy;

  // no request is taken while reset is held
  assign in_stall = busy || rst;

  clcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .busy     (busy),
    .status   (status),
    .cmd      (cmd)
  );

  clcd_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .func       (func),
    .byte_value (byte_value),
    .row        (row),
    .col        (col),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reg_select (reg_select),
    .nibble     (nibble),
    .enable     (enable),
    .hold_ms    (hold_ms),
    .last       (last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

endmodule

@@ design/clcd_ctrl.sv @@
`include "assert_macros.svh"

module clcd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [2:0]          func,
  output logic                busy,
  input  clcd_pkg::dp_status_t status,
  output clcd_pkg::ctrl_cmd_t  cmd
);

  clcd_pkg::state_t state, state_next;
  logic [2:0] step, step_next;
  logic [2:0] seq, seq_next;
  logic       clear_req, clear_req_next;
  logic       adv;

  assign adv = status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= clcd_pkg::ST_IDLE;
      step      <= 3'd0;
      seq       <= 3'd0;
      clear_req <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      seq       <= seq_next;
      clear_req <= clear_req_next;
    end
  end

  always_comb begin
    state_next     = state;
    step_next      = step;
    seq_next       = seq;
    clear_req_next = clear_req;
    unique case (state)
      clcd_pkg::ST_IDLE: begin
        step_next = 3'd0;
        seq_next  = 3'd0;
        if (in_valid) begin
          clear_req_next = (func == clcd_pkg::FUNC_CLEAR);
          if (func == clcd_pkg::FUNC_CMD || func == clcd_pkg::FUNC_DATA ||
              func == clcd_pkg::FUNC_CURSOR || func == clcd_pkg::FUNC_CLEAR) begin
            state_next = clcd_pkg::ST_BYTE;
          end else if (func == clcd_pkg::FUNC_INIT) begin
            state_next = clcd_pkg::ST_PWR;
          end
        end
      end
      clcd_pkg::ST_PWR: begin
        if (adv) begin
          state_next = clcd_pkg::ST_INIT_NIB;
        end
      end
      clcd_pkg::ST_INIT_NIB: begin
        if (adv) begin
          if (step == clcd_pkg::STEP_NIB_LAST) begin
            step_next = 3'd0;
            if (seq == clcd_pkg::SEQ_NIB_LAST) begin
              seq_next   = 3'd0;
              state_next = clcd_pkg::ST_INIT_BYTE;
            end else begin
              seq_next = seq + 3'd1;
            end
          end else begin
            step_next = step + 3'd1;
          end
        end
      end
      clcd_pkg::ST_INIT_BYTE: begin
        if (adv) begin
          if (step == clcd_pkg::STEP_BYTE_LAST) begin
            step_next = 3'd0;
            if (seq == clcd_pkg::SEQ_BYTE_LAST) begin
              state_next = clcd_pkg::ST_IDLE;
            end else begin
              seq_next = seq + 3'd1;
            end
          end else begin
            step_next = step + 3'd1;
          end
        end
      end
      clcd_pkg::ST_BYTE: begin
        if (adv) begin
          if (step == clcd_pkg::STEP_BYTE_LAST) begin
            step_next  = 3'd0;
            state_next = clear_req ? clcd_pkg::ST_EXTRA : clcd_pkg::ST_IDLE;
          end else begin
            step_next = step + 3'd1;
          end
        end
      end
      clcd_pkg::ST_EXTRA: begin
        if (adv) begin
          state_next = clcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = clcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy     = (state != clcd_pkg::ST_IDLE);
    cmd.load = (state == clcd_pkg::ST_IDLE) && in_valid;
    cmd.emit = (state != clcd_pkg::ST_IDLE) && adv;
    cmd.step = step;
    cmd.seq  = seq;
    cmd.kind = clcd_pkg::K_BYTE;
    cmd.last = 1'b0;
    unique case (state)
      clcd_pkg::ST_IDLE:      cmd.kind = clcd_pkg::K_BYTE;
      clcd_pkg::ST_PWR:       cmd.kind = clcd_pkg::K_PWR;
      clcd_pkg::ST_INIT_NIB:  cmd.kind = clcd_pkg::K_INIT_NIB;
      clcd_pkg::ST_INIT_BYTE: begin
        cmd.kind = clcd_pkg::K_INIT_BYTE;
        cmd.last = (step == clcd_pkg::STEP_BYTE_LAST) && (seq == clcd_pkg::SEQ_BYTE_LAST);
      end
      clcd_pkg::ST_BYTE: begin
        cmd.kind = clcd_pkg::K_BYTE;
        cmd.last = (step == clcd_pkg::STEP_BYTE_LAST) && !clear_req;
      end
      clcd_pkg::ST_EXTRA: begin
        cmd.kind = clcd_pkg::K_EXTRA;
        cmd.last = 1'b1;
      end
      default: cmd.kind = clcd_pkg::K_BYTE;
    endcase
  end

  `CLCD_ASSERT(a_emit_when_free, cmd.emit |-> status.out_free, "phase emitted into full output")
  `CLCD_ASSERT(a_last_returns_idle, cmd.emit && cmd.last |=> state == clcd_pkg::ST_IDLE, "no idle after last phase")
  `CLCD_ASSERT(a_step_range, step <= clcd_pkg::STEP_BYTE_LAST, "phase step out of range")
  `CLCD_ASSERT(a_idle_counters, state == clcd_pkg::ST_IDLE |-> step == 3'd0, "step not cleared in idle")

endmodule

@@ design/clcd_datapath.sv @@
`include "assert_macros.svh"

module clcd_datapath (
  input  logic                clk,
  input  logic                rst,
  // request fields
  input  logic [2:0]          func,
  input  logic [7:0]          byte_value,
  input  logic                row,
  input  logic [5:0]          col,
  // control
  input  clcd_pkg::ctrl_cmd_t  cmd,
  output clcd_pkg::dp_status_t status,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                reg_select,
  output logic [3:0]          nibble,
  output logic                enable,
  output logic [7:0]          hold_ms,
  output logic                last,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [3:0] pulse_hold_ms;
  logic [7:0] power_on_wait_ms;
  logic [7:0] byte_reg;
  logic       rs_reg;
  logic       wr_en;

  logic [7:0] cur_byte;
  logic       ph_rs;
  logic [3:0] ph_nib;
  logic       ph_en;
  logic [7:0] ph_hold;
  logic [7:0] pulse8;
  logic [7:0] settle;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_hold_ms    <= clcd_pkg::PULSE_HOLD_RESET;
      power_on_wait_ms <= clcd_pkg::POWER_WAIT_RESET;
    end else if (wr_en) begin
      if (paddr[2] == clcd_pkg::REG_PULSE_HOLD) begin
        pulse_hold_ms <= pwdata[3:0];
      end else begin
        power_on_wait_ms <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == clcd_pkg::REG_PULSE_HOLD) begin
      prdata = {28'd0, pulse_hold_ms};
    end else begin
      prdata = {24'd0, power_on_wait_ms};
    end
  end

  // request capture: cursor address is 0x80 | row*0x40 | col
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rs_reg <= (func == clcd_pkg::FUNC_DATA);
      priority if (func == clcd_pkg::FUNC_CURSOR) begin
        byte_reg <= clcd_pkg::CMD_SET_ADDR | {1'b0, row, col};
      end else if (func == clcd_pkg::FUNC_CLEAR) begin
        byte_reg <= clcd_pkg::CMD_CLEAR;
      end else begin
        byte_reg <= byte_value;
      end
    end
  end

  assign pulse8   = {4'd0, pulse_hold_ms};
  assign cur_byte = (cmd.kind == clcd_pkg::K_INIT_BYTE) ? clcd_pkg::init_byte(cmd.seq)
                                                         : byte_reg;

  always_comb begin
    priority if ((cmd.kind == clcd_pkg::K_BYTE) && rs_reg) begin
      settle = clcd_pkg::SETTLE_DATA;
    end else if (cur_byte == clcd_pkg::CMD_CLEAR || cur_byte == clcd_pkg::CMD_HOME) begin
      settle = clcd_pkg::SETTLE_LONG;
    end else begin
      settle = clcd_pkg::SETTLE_CMD;
    end
  end

  always_comb begin
    ph_rs   = 1'b0;
    ph_nib  = 4'd0;
    ph_en   = 1'b0;
    ph_hold = pulse8;
    unique case (cmd.kind)
      clcd_pkg::K_PWR: begin
        ph_hold = power_on_wait_ms;
      end
      clcd_pkg::K_INIT_NIB: begin
        ph_nib = (cmd.seq == clcd_pkg::SEQ_NIB_LAST) ? clcd_pkg::NIB_4BIT : clcd_pkg::NIB_WAKE;
        ph_en  = (cmd.step == 3'd0);
        if (cmd.step == clcd_pkg::STEP_NIB_LAST) begin
          ph_hold = (cmd.seq == 3'd0) ? clcd_pkg::SETTLE_LONG : clcd_pkg::SETTLE_DATA;
        end
      end
      clcd_pkg::K_INIT_BYTE, clcd_pkg::K_BYTE: begin
        ph_rs  = (cmd.kind == clcd_pkg::K_BYTE) && rs_reg;
        ph_nib = (cmd.step < 3'd2) ? cur_byte[7:4] : cur_byte[3:0];
        ph_en  = (cmd.step == 3'd0) || (cmd.step == 3'd2);
        if (cmd.step == clcd_pkg::STEP_BYTE_LAST) begin
          ph_hold = settle;
        end
      end
      clcd_pkg::K_EXTRA: begin
        ph_nib  = clcd_pkg::CMD_CLEAR[3:0];
        ph_hold = clcd_pkg::SETTLE_LONG;
      end
      default: begin
        ph_hold = pulse8;
      end
    endcase
  end

  // output register: one phase beat, refilled as soon as it is taken
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      reg_select <= ph_rs;
      nibble     <= ph_nib;
      enable     <= ph_en;
      hold_ms    <= ph_hold;
      last       <= cmd.last;
    end
  end

  `CLCD_ASSERT(a_last_enable_low, out_valid && last |-> !enable, "last phase with enable high")
  `CLCD_ASSERT(a_pulse_hold, out_valid && enable |-> reg_select == rs_reg || !reg_select, "rs mismatch on pulse")
  `CLCD_ASSERT_ALWAYS(a_pready_high, pready, "pready low")

endmodule
